>>> hdl/ictd_pkg.sv
package ictd_pkg;

  typedef enum logic [4:0] {
    K_NULL  = 5'd0,
    K_UNK   = 5'd1,
    K_MOV   = 5'd2,
    K_LOAD  = 5'd3,
    K_STORE = 5'd4,
    K_ADD   = 5'd5,
    K_SUB   = 5'd6,
    K_MUL   = 5'd7,
    K_DIV   = 5'd8,
    K_MOD   = 5'd9,
    K_AND   = 5'd10,
    K_OR    = 5'd11,
    K_XOR   = 5'd12,
    K_SHL   = 5'd13,
    K_SHR   = 5'd14,
    K_ILL   = 5'd15,
    K_RET   = 5'd16,
    K_UJMP  = 5'd17,
    K_UCALL = 5'd18,
    K_CMOV  = 5'd19,
    K_TRAP  = 5'd20,
    K_SWI   = 5'd21,
    K_IO    = 5'd22,
    K_NOT   = 5'd23,
    K_ABS   = 5'd24,
    K_CMP   = 5'd25,
    K_CALL  = 5'd26,
    K_CJMP  = 5'd27,
    K_JMP   = 5'd28,
    K_PUSH  = 5'd29,
    K_NOP   = 5'd30
  } kind_t;

  typedef struct packed {
    logic [31:0] address;
    logic [7:0]  byte_zero;
    logic [7:0]  byte_one;
    logic [7:0]  byte_two;
    logic [7:0]  bytes_available;
  } in_t;

  typedef struct packed {
    logic [3:0]  length;
    kind_t       kind;
    logic        is_fpu;
    logic [31:0] jump_target;
    logic [31:0] fall_through;
    logic [31:0] pointer;
    logic        truncated;
  } out_t;

  // Decode summary handed from the classifier to the address stages
  typedef struct packed {
    logic [3:0]  length;
    logic        truncated;
    kind_t       kind;
    logic        is_fpu;
    logic        has_jump;
    logic        has_fall;
    logic        has_ptr;
    logic        call_align;
    logic [31:0] offset;
  } dec_t;

  localparam logic [31:0] PTR_BIAS = 32'h0004_0000;

  localparam logic [3:0] LEN_BY_OP0 [0:15] = '{
    4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3,
    4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd8, 4'd8
  };

  localparam kind_t RST2_KIND [0:15] = '{
    K_AND, K_AND, K_OR,  K_OR,  K_XOR, K_UNK, K_UNK, K_UNK,
    K_MUL, K_UNK, K_MUL, K_MUL, K_DIV, K_DIV, K_MOD, K_MOD
  };

  localparam kind_t RST1_KIND [0:15] = '{
    K_SHL, K_SHL, K_SHR, K_SHR, K_SHR, K_UNK, K_NULL, K_UNK,
    K_SHR, K_SHR, K_SHL, K_SHR, K_MUL, K_MUL, K_UNK,  K_UNK
  };

  localparam kind_t LSAI_KIND [0:15] = '{
    K_LOAD, K_LOAD, K_LOAD, K_UNK, K_STORE, K_STORE, K_STORE, K_NULL,
    K_UNK,  K_LOAD, K_MOV,  K_LOAD, K_ADD,  K_ADD,  K_STORE, K_STORE
  };

endpackage

>>> hdl/instruction_class_and_target_decoder.sv
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_ready   | in_t : address, three bytes, bytes available
// out_    | output    | out_valid/out_ready | out_t: length, kind, fpu, targets, truncated
//
// Three register stages: classify and pick the offset, form the base
// addresses, add the offset into the output register. One beat per cycle
// is sustained while out_ready stays high.
// rst_n is synchronous and active low; it clears the stage valid bits only.
// Each stage advances when it is empty or the stage after it moves, so a
// stall on out_ready fills the pipeline bubble-free and drops nothing.
module instruction_class_and_target_decoder import ictd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  // Stage 1: decode summary plus the address it belongs to
  typedef struct packed {
    dec_t        dec;
    logic [31:0] addr;
  } s1_t;

  // Stage 2: decode summary plus the chosen base and the fall-through address
  typedef struct packed {
    dec_t        dec;
    logic [31:0] base;
    logic [31:0] fall;
  } s2_t;

  dec_t        dec;
  s1_t         s1_r, s1_nxt;
  s2_t         s2_r, s2_nxt;
  out_t        out_r, out_nxt;
  logic        s1_valid_r, s2_valid_r, out_valid_r;
  logic        s1_valid_nxt, s2_valid_nxt, out_valid_nxt;
  logic        s1_rdy, s2_rdy, out_adv;
  logic [31:0] pc4, aligned, sum;

  ictd_decode u_decode (
    .beat (in_data),
    .dec  (dec)
  );

  // Advance a stage when it holds nothing or its successor moves on
  assign out_adv  = !out_valid_r || out_ready;
  assign s2_rdy   = !s2_valid_r || out_adv;
  assign s1_rdy   = !s1_valid_r || s2_rdy;
  assign in_ready = s1_rdy;

  assign s1_valid_nxt  = s1_rdy  ? in_valid   : s1_valid_r;
  assign s2_valid_nxt  = s2_rdy  ? s1_valid_r : s2_valid_r;
  assign out_valid_nxt = out_adv ? s2_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Stage 1 capture
  always_comb begin
    s1_nxt.dec  = dec;
    s1_nxt.addr = in_data.address;
  end

  // Stage 2: the literal pointer works from the word-aligned address rounded up,
  // every branch and call from the address plus four
  assign pc4     = s1_r.addr + 32'd4;
  assign aligned = (s1_r.addr + 32'd3) & ~32'd3;

  always_comb begin
    s2_nxt.dec  = s1_r.dec;
    s2_nxt.base = s1_r.dec.has_ptr ? aligned : pc4;
    s2_nxt.fall = s1_r.addr + {28'd0, s1_r.dec.length};
  end

  // Stage 3: one shared adder serves jump, call and literal targets
  assign sum = s2_r.base + s2_r.dec.offset;

  always_comb begin
    out_nxt              = '0;
    out_nxt.length       = s2_r.dec.length;
    out_nxt.kind         = s2_r.dec.kind;
    out_nxt.is_fpu       = s2_r.dec.is_fpu;
    out_nxt.truncated    = s2_r.dec.truncated;
    if (s2_r.dec.has_jump) begin
      // calls land on a word boundary
      out_nxt.jump_target = s2_r.dec.call_align ? {sum[31:2], 2'b00} : sum;
    end
    if (s2_r.dec.has_fall) begin
      out_nxt.fall_through = s2_r.fall;
    end
    if (s2_r.dec.has_ptr) begin
      out_nxt.pointer = sum;
    end
  end

  // Payload registers load only when their stage takes a fresh beat
  always_ff @(posedge clk) begin
    if (in_valid && s1_rdy) begin
      s1_r <= s1_nxt;
    end
    if (s1_valid_r && s2_rdy) begin
      s2_r <= s2_nxt;
    end
    if (s2_valid_r && out_adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A cut-short instruction carries no class and no addresses
  a_trunc_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.truncated |->
      out_data.kind == K_NULL && !out_data.is_fpu && out_data.jump_target == 32'd0 &&
      out_data.fall_through == 32'd0 && out_data.pointer == 32'd0)
    else $error("truncated beat carries decode fields");

  // Fall-through is only given for calls and conditional branches
  a_fall_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.fall_through != 32'd0 |->
      out_data.kind == K_CALL || out_data.kind == K_CJMP)
    else $error("fall-through on a beat that is no call or branch");

  // A literal pointer only comes with a load
  a_ptr_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.pointer != 32'd0 |-> out_data.kind == K_LOAD)
    else $error("pointer on a beat that is no load");

  // Input back-pressure only when every stage is full and the output stalls
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && s2_valid_r && out_valid_r && !out_ready)
    else $error("input held off with room in the pipeline");

  // Call targets stay word aligned
  a_call_align: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == K_CALL |-> out_data.jump_target[1:0] == 2'b00)
    else $error("call target not word aligned");

endmodule

>>> hdl/ictd_decode.sv
module ictd_decode import ictd_pkg::*; (
  input  in_t  beat,
  output dec_t dec
);

  function automatic kind_t st0_kind(input logic [3:0] t, input logic [3:0] s,
                                     input logic [3:0] r);
    kind_t k;
    k = K_UNK;
    unique case (r)
      4'h0: begin
        if (t <= 4'd3) k = K_ILL;
        else if (t == 4'h8 || t == 4'h9) k = K_RET;
        else if (t == 4'ha) k = K_UJMP;
        else if (t >= 4'hc) k = K_UCALL;
      end
      4'h1: k = K_CMOV;
      4'h2: begin
        if (t <= 4'd3 || t == 4'h8 || t == 4'hc || t == 4'hd) k = K_NULL;
      end
      4'h3: begin
        if (t == 4'h0) begin
          if (s <= 4'd2 || s == 4'h4 || s == 4'h5) k = K_RET;
        end else if (t == 4'h1 || t == 4'h2) begin
          k = K_RET;
        end
      end
      4'h4: k = K_TRAP;
      4'h5, 4'h6, 4'h7: k = K_SWI;
      4'h8, 4'h9, 4'ha, 4'hb: k = K_MOV;
      default: k = K_UNK;
    endcase
    return k;
  endfunction

  function automatic kind_t st1_kind(input logic [3:0] r);
    kind_t k;
    k = K_UNK;
    if (r <= 4'd4 || r >= 4'he) k = K_NULL;
    else if (r == 4'h6 || r == 4'h7) k = K_IO;
    else if (r == 4'h8) k = K_SWI;
    return k;
  endfunction

  function automatic kind_t qrst_kind(input logic [3:0] t, input logic [3:0] s,
                                      input logic [3:0] r, input logic [3:0] op1,
                                      input logic [3:0] op2);
    kind_t k;
    k = K_UNK;
    unique case (op1)
      4'd0: begin
        unique case (op2)
          4'd0: k = st0_kind(t, s, r);
          4'd1: k = K_AND;
          4'd2: k = K_OR;
          4'd3: k = K_XOR;
          4'd4: k = st1_kind(r);
          4'd5: k = K_MOV;
          4'd6: k = (s == 4'd0) ? K_NOT : (s == 4'd1) ? K_MOV : K_UNK;
          4'd7: k = K_UNK;
          default: k = (op2 < 4'd12) ? K_ADD : K_SUB;
        endcase
      end
      4'd1: begin
        if (op2 == 4'hf) begin
          if (r <= 4'd3 || r == 4'h8 || r == 4'h9) k = K_NULL;
          else if (r == 4'he && t <= 4'd1) k = K_RET;
          else k = K_UNK;
        end else begin
          k = RST1_KIND[op2];
        end
      end
      4'd2: k = RST2_KIND[op2];
      4'd3: k = K_MOV;
      4'd4, 4'd5: k = K_NULL;
      4'd8: k = (op2 <= 4'd1) ? K_LOAD : (op2 == 4'd4 || op2 == 4'd5) ? K_STORE : K_UNK;
      4'd9: k = (op2 == 4'd0) ? K_LOAD : (op2 == 4'd4) ? K_STORE : K_UNK;
      4'd10: begin
        if (op2 == 4'd0 || op2 == 4'd4) k = K_ADD;
        else if (op2 == 4'd1 || op2 == 4'd5) k = K_SUB;
        else if (op2 == 4'd2) k = K_MUL;
        else if (op2 >= 4'd8 && op2 <= 4'he) k = K_MOV;
        else if (op2 == 4'hf) begin
          if (t == 4'd0 || t == 4'd4 || t == 4'd5) k = K_MOV;
          else if (t == 4'd1) k = K_ABS;
          else if (t == 4'd6) k = K_NOT;
          else k = K_UNK;
        end else k = K_UNK;
      end
      4'd11: begin
        if (op2 >= 4'd1 && op2 <= 4'd7) k = K_CMP;
        else if (op2 >= 4'd8 && op2 <= 4'hd) k = K_MOV;
        else k = K_UNK;
      end
      default: k = K_UNK;
    endcase
    return k;
  endfunction

  logic [7:0]  b0, b1, b2;
  logic [3:0]  op0, t, s, r, op1, op2;
  logic [3:0]  len;
  logic        trunc;
  logic [31:0] sext8;
  dec_t        raw;

  assign b0    = beat.byte_zero;
  assign b1    = beat.byte_one;
  assign b2    = beat.byte_two;
  assign op0   = b0[3:0];
  assign t     = b0[7:4];
  assign s     = b1[3:0];
  assign r     = b1[7:4];
  assign op1   = b2[3:0];
  assign op2   = b2[7:4];
  assign len   = LEN_BY_OP0[op0];
  assign trunc = {4'd0, len} > beat.bytes_available;
  assign sext8 = {{24{b2[7]}}, b2};

  always_comb begin
    raw            = '0;
    raw.kind       = K_NULL;
    raw.length     = len;
    raw.truncated  = trunc;
    unique case (op0)
      4'd0: begin
        raw.kind   = qrst_kind(t, s, r, op1, op2);
        raw.is_fpu = (op1 == 4'd8 || op1 == 4'd10 || op1 == 4'd11);
      end
      4'd1: begin
        raw.kind    = K_LOAD;
        raw.has_ptr = 1'b1;
        raw.offset  = {14'd0, b2, b1, 2'b00} - PTR_BIAS;
      end
      4'd2: raw.kind = LSAI_KIND[r];
      4'd3: begin
        raw.is_fpu = 1'b1;
        raw.kind   = (r[1:0] == 2'd0) ? (r[2] ? K_STORE : K_LOAD) : K_UNK;
      end
      4'd5: begin
        raw.kind       = K_CALL;
        raw.has_jump   = 1'b1;
        raw.has_fall   = 1'b1;
        raw.call_align = 1'b1;
        raw.offset     = {{12{b2[7]}}, b2, b1, b0[7:6], 2'b00};
      end
      4'd6: begin
        unique case (b0[5:4])
          2'd0: begin
            raw.kind     = K_JMP;
            raw.has_jump = 1'b1;
            raw.offset   = {{14{b2[7]}}, b2, b1, b0[7:6]};
          end
          2'd1: begin
            raw.kind     = K_CJMP;
            raw.has_jump = 1'b1;
            raw.has_fall = 1'b1;
            raw.offset   = {{20{b2[7]}}, b2, b1[7:4]};
          end
          2'd2: begin
            raw.kind     = K_CJMP;
            raw.has_jump = 1'b1;
            raw.has_fall = 1'b1;
            raw.offset   = sext8;
          end
          default: begin
            if (b0[7:6] == 2'd0) begin
              raw.kind = K_PUSH;
            end else if (b0[7:6] == 2'd1) begin
              if (r <= 4'd1) begin
                raw.kind     = K_CJMP;
                raw.has_jump = 1'b1;
                raw.has_fall = 1'b1;
                raw.offset   = sext8;
              end else if (r >= 4'h8 && r <= 4'ha) begin
                raw.kind     = K_CJMP;
                raw.has_jump = 1'b1;
                raw.has_fall = 1'b1;
                raw.offset   = {24'd0, b2};
              end else begin
                raw.kind = K_UNK;
              end
            end else begin
              raw.kind     = K_CJMP;
              raw.has_jump = 1'b1;
              raw.has_fall = 1'b1;
              raw.offset   = sext8;
            end
          end
        endcase
      end
      4'd7: begin
        raw.kind     = K_CJMP;
        raw.has_jump = 1'b1;
        raw.has_fall = 1'b1;
        raw.offset   = sext8;
      end
      4'd8: raw.kind = K_LOAD;
      4'd9: raw.kind = K_STORE;
      4'd10, 4'd11: raw.kind = K_ADD;
      4'd12: begin
        if (b0[7]) begin
          raw.kind     = K_CJMP;
          raw.has_jump = 1'b1;
          raw.has_fall = 1'b1;
          raw.offset   = {26'd0, b0[5:4], b1[7:4]};
        end else begin
          raw.kind = K_MOV;
        end
      end
      4'd13: begin
        if (r == 4'd0) raw.kind = K_MOV;
        else if (r == 4'hf) begin
          if (t <= 4'd1) raw.kind = K_RET;
          else if (t == 4'd2) raw.kind = K_TRAP;
          else if (t == 4'd3) raw.kind = K_NOP;
          else if (t == 4'd6) raw.kind = K_ILL;
          else raw.kind = K_UNK;
        end else raw.kind = K_UNK;
      end
      default: raw.kind = K_NULL;
    endcase
  end

  // Drop everything but length and the flag when the instruction is cut short
  always_comb begin
    dec = raw;
    if (trunc) begin
      dec           = '0;
      dec.kind      = K_NULL;
      dec.length    = len;
      dec.truncated = 1'b1;
    end
  end

endmodule
